FILE: hw/rtl/subpixel_peak_centroid_3x3_assert.svh
// Assertion macros shared by the centroid block.
// Each macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef SUBPIXEL_PEAK_CENTROID_3X3_ASSERT_SVH
`define SUBPIXEL_PEAK_CENTROID_3X3_ASSERT_SVH

// Same-cycle implication.
`define SPC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SPC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/spc_pkg.sv
`default_nettype none
package spc_pkg;

  localparam int SCORE_W  = 16;
  localparam int COORD_W  = 12;
  localparam int DIM_W    = 13;
  localparam int OUT_W    = 20;
  localparam int OUT_FRAC = 8;
  localparam int STATUS_W = 2;
  localparam int CFG_IDX_W = 2;

  // Column and row partial sums of three scores, full sum of nine, differences.
  localparam int PSUM_W = SCORE_W + 2;
  localparam int SUM_W  = SCORE_W + 4;
  localparam int DIFF_W = SCORE_W + 3;
  // Coordinate times score sum, plus the difference term.
  localparam int PROD_W = COORD_W + 1 + SUM_W;
  localparam int MAG_W  = 31;
  localparam int DEN_W  = SUM_W - 1;
  // Rounded dividend (2 * n * 2^OUT_FRAC + d).
  localparam int REM_W  = MAG_W + OUT_FRAC + 2;
  localparam int QUO_W  = OUT_W;
  localparam int N_CELLS = QUO_W;

  localparam logic [DIM_W-1:0] MAX_DIM = 13'd4096;
  localparam logic [DIM_W-1:0] DIM_RESET = 13'd4096;
  localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BORDER = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ZERO   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_SPACE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPACE_HEIGHT = 2'd1;

  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
  } spc_dims_t;

  typedef struct packed {
    logic signed [SCORE_W-1:0] score_up_left;
    logic signed [SCORE_W-1:0] score_up;
    logic signed [SCORE_W-1:0] score_up_right;
    logic signed [SCORE_W-1:0] score_left;
    logic signed [SCORE_W-1:0] score_center;
    logic signed [SCORE_W-1:0] score_right;
    logic signed [SCORE_W-1:0] score_down_left;
    logic signed [SCORE_W-1:0] score_down;
    logic signed [SCORE_W-1:0] score_down_right;
    logic [COORD_W-1:0]        peak_col;
    logic [COORD_W-1:0]        peak_row;
  } spc_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                neg_x;
    logic                neg_y;
    logic                ovf_x;
    logic                ovf_y;
    logic [OUT_W-1:0]    px;
    logic [OUT_W-1:0]    py;
  } spc_side_t;

  typedef struct packed {
    logic [REM_W-1:0] rem_x;
    logic [REM_W-1:0] rem_y;
    logic [REM_W-1:0] dvs;
    logic [QUO_W-1:0] q_x;
    logic [QUO_W-1:0] q_y;
    spc_side_t        side;
  } spc_div_t;

endpackage
`default_nettype wire

FILE: hw/rtl/spc_if.sv
`default_nettype none
interface spc_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [spc_pkg::SCORE_W-1:0] score_up_left;
  logic signed [spc_pkg::SCORE_W-1:0] score_up;
  logic signed [spc_pkg::SCORE_W-1:0] score_up_right;
  logic signed [spc_pkg::SCORE_W-1:0] score_left;
  logic signed [spc_pkg::SCORE_W-1:0] score_center;
  logic signed [spc_pkg::SCORE_W-1:0] score_right;
  logic signed [spc_pkg::SCORE_W-1:0] score_down_left;
  logic signed [spc_pkg::SCORE_W-1:0] score_down;
  logic signed [spc_pkg::SCORE_W-1:0] score_down_right;
  logic [spc_pkg::COORD_W-1:0]        peak_col;
  logic [spc_pkg::COORD_W-1:0]        peak_row;

  modport source (
    output valid, score_up_left, score_up, score_up_right, score_left, score_center,
           score_right, score_down_left, score_down, score_down_right, peak_col, peak_row,
    input  ready
  );
  modport sink (
    input  valid, score_up_left, score_up, score_up_right, score_left, score_center,
           score_right, score_down_left, score_down, score_down_right, peak_col, peak_row,
    output ready
  );
endinterface

interface spc_out_if;
  logic                         valid;
  logic                         ready;
  logic [spc_pkg::OUT_W-1:0]    refined_x;
  logic [spc_pkg::OUT_W-1:0]    refined_y;
  logic [spc_pkg::STATUS_W-1:0] status;

  modport source (output valid, refined_x, refined_y, status, input ready);
  modport sink (input valid, refined_x, refined_y, status, output ready);
endinterface

interface spc_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [spc_pkg::CFG_IDX_W-1:0] index;
  logic [spc_pkg::DIM_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/spc_prep.sv
`default_nettype none
module spc_prep (
  input  logic              clk,
  input  logic              rst_n,
  input  spc_pkg::spc_dims_t dims,
  input  logic              up_valid,
  output logic              up_ready,
  input  spc_pkg::spc_in_t  up_data,
  output logic              dn_valid,
  input  logic              dn_ready,
  output spc_pkg::spc_div_t dn_data
);

  logic [4:0] v_r;
  logic [4:0] v_nxt;
  logic [4:0] rdy;

  // Stage 1: partial sums and border check.
  logic signed [spc_pkg::PSUM_W-1:0] s1_l_r, s1_m_r, s1_r_r, s1_u_r, s1_d_r;
  logic [spc_pkg::COORD_W-1:0]       s1_col_r, s1_row_r;
  logic                              s1_border_r;
  // Stage 2: full sum and differences.
  logic signed [spc_pkg::SUM_W-1:0]  s2_total_r;
  logic signed [spc_pkg::DIFF_W-1:0] s2_dx_r, s2_dy_r;
  logic [spc_pkg::COORD_W-1:0]       s2_col_r, s2_row_r;
  logic [spc_pkg::STATUS_W-1:0]      s2_status_r;
  // Stage 3: coordinate times sum.
  logic signed [spc_pkg::PROD_W-1:0] s3_prod_x_r, s3_prod_y_r;
  logic signed [spc_pkg::DIFF_W-1:0] s3_dx_r, s3_dy_r;
  logic signed [spc_pkg::SUM_W-1:0]  s3_total_r;
  logic [spc_pkg::COORD_W-1:0]       s3_col_r, s3_row_r;
  logic [spc_pkg::STATUS_W-1:0]      s3_status_r;
  // Stage 4: magnitudes and signs.
  logic [spc_pkg::MAG_W-1:0]         s4_nx_r, s4_ny_r;
  logic                              s4_neg_x_r, s4_neg_y_r;
  logic [spc_pkg::DEN_W-1:0]         s4_d_r;
  logic [spc_pkg::COORD_W-1:0]       s4_col_r, s4_row_r;
  logic [spc_pkg::STATUS_W-1:0]      s4_status_r;
  // Stage 5: divider set-up.
  spc_pkg::spc_div_t                 s5_r;

  logic [spc_pkg::DIM_W-1:0]         w_c, h_c;
  logic [spc_pkg::DIM_W:0]           col_p2, row_p2;
  logic                              border_c;
  logic signed [spc_pkg::SUM_W-1:0]  total_c;
  logic signed [spc_pkg::PROD_W-1:0] prod_x_c, prod_y_c, tx_c, ty_c, tx_abs, ty_abs;
  logic signed [spc_pkg::SUM_W-1:0]  tot_abs;
  logic [spc_pkg::REM_W-1:0]         num_x_c, num_y_c, lim_c;

  always_comb begin
    rdy[4] = !v_r[4] || dn_ready;
    for (int i = 3; i >= 0; i--) begin
      rdy[i] = !v_r[i] || rdy[i+1];
    end
    v_nxt[0] = rdy[0] ? up_valid : v_r[0];
    for (int i = 1; i < 5; i++) begin
      v_nxt[i] = rdy[i] ? v_r[i-1] : v_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_comb begin
    w_c = (dims.width > spc_pkg::MAX_DIM) ? spc_pkg::MAX_DIM : dims.width;
    h_c = (dims.height > spc_pkg::MAX_DIM) ? spc_pkg::MAX_DIM : dims.height;
    col_p2 = {2'b00, up_data.peak_col} + 14'd2;
    row_p2 = {2'b00, up_data.peak_row} + 14'd2;
    border_c = (up_data.peak_col == '0) || (up_data.peak_row == '0)
            || (col_p2 > {1'b0, w_c}) || (row_p2 > {1'b0, h_c});
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      s1_l_r <= spc_pkg::PSUM_W'(up_data.score_up_left) + spc_pkg::PSUM_W'(up_data.score_left)
              + spc_pkg::PSUM_W'(up_data.score_down_left);
      s1_m_r <= spc_pkg::PSUM_W'(up_data.score_up) + spc_pkg::PSUM_W'(up_data.score_center)
              + spc_pkg::PSUM_W'(up_data.score_down);
      s1_r_r <= spc_pkg::PSUM_W'(up_data.score_up_right) + spc_pkg::PSUM_W'(up_data.score_right)
              + spc_pkg::PSUM_W'(up_data.score_down_right);
      s1_u_r <= spc_pkg::PSUM_W'(up_data.score_up_left) + spc_pkg::PSUM_W'(up_data.score_up)
              + spc_pkg::PSUM_W'(up_data.score_up_right);
      s1_d_r <= spc_pkg::PSUM_W'(up_data.score_down_left) + spc_pkg::PSUM_W'(up_data.score_down)
              + spc_pkg::PSUM_W'(up_data.score_down_right);
      s1_col_r    <= up_data.peak_col;
      s1_row_r    <= up_data.peak_row;
      s1_border_r <= border_c;
    end
  end

  assign total_c = spc_pkg::SUM_W'(s1_l_r) + spc_pkg::SUM_W'(s1_m_r) + spc_pkg::SUM_W'(s1_r_r);

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s2_total_r <= total_c;
      s2_dx_r    <= spc_pkg::DIFF_W'(s1_r_r) - spc_pkg::DIFF_W'(s1_l_r);
      s2_dy_r    <= spc_pkg::DIFF_W'(s1_d_r) - spc_pkg::DIFF_W'(s1_u_r);
      s2_col_r   <= s1_col_r;
      s2_row_r   <= s1_row_r;
      if (s1_border_r) begin
        s2_status_r <= spc_pkg::ST_BORDER;
      end else if (total_c == '0) begin
        s2_status_r <= spc_pkg::ST_ZERO;
      end else begin
        s2_status_r <= spc_pkg::ST_OK;
      end
    end
  end

  assign prod_x_c = $signed({1'b0, s2_col_r}) * s2_total_r;
  assign prod_y_c = $signed({1'b0, s2_row_r}) * s2_total_r;

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      s3_prod_x_r <= prod_x_c;
      s3_prod_y_r <= prod_y_c;
      s3_dx_r     <= s2_dx_r;
      s3_dy_r     <= s2_dy_r;
      s3_total_r  <= s2_total_r;
      s3_col_r    <= s2_col_r;
      s3_row_r    <= s2_row_r;
      s3_status_r <= s2_status_r;
    end
  end

  // Weighted sum is peak * total + difference term.
  always_comb begin
    tx_c    = s3_prod_x_r + spc_pkg::PROD_W'(s3_dx_r);
    ty_c    = s3_prod_y_r + spc_pkg::PROD_W'(s3_dy_r);
    tx_abs  = tx_c[spc_pkg::PROD_W-1] ? -tx_c : tx_c;
    ty_abs  = ty_c[spc_pkg::PROD_W-1] ? -ty_c : ty_c;
    tot_abs = s3_total_r[spc_pkg::SUM_W-1] ? -s3_total_r : s3_total_r;
  end

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      s4_nx_r     <= tx_abs[spc_pkg::MAG_W-1:0];
      s4_ny_r     <= ty_abs[spc_pkg::MAG_W-1:0];
      s4_neg_x_r  <= tx_c[spc_pkg::PROD_W-1] ^ s3_total_r[spc_pkg::SUM_W-1];
      s4_neg_y_r  <= ty_c[spc_pkg::PROD_W-1] ^ s3_total_r[spc_pkg::SUM_W-1];
      s4_d_r      <= tot_abs[spc_pkg::DEN_W-1:0];
      s4_col_r    <= s3_col_r;
      s4_row_r    <= s3_row_r;
      s4_status_r <= s3_status_r;
    end
  end

  // Rounded dividend 2*n*2^frac + d over divisor 2d; saturate where quotient needs
  // more than the output width.
  always_comb begin
    num_x_c = {1'b0, s4_nx_r, {(spc_pkg::OUT_FRAC+1){1'b0}}} + spc_pkg::REM_W'(s4_d_r);
    num_y_c = {1'b0, s4_ny_r, {(spc_pkg::OUT_FRAC+1){1'b0}}} + spc_pkg::REM_W'(s4_d_r);
    lim_c   = {1'b0, s4_d_r, {(spc_pkg::OUT_W+1){1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      s5_r.rem_x       <= num_x_c;
      s5_r.rem_y       <= num_y_c;
      s5_r.dvs         <= {2'b00, s4_d_r, {spc_pkg::OUT_W{1'b0}}};
      s5_r.q_x         <= '0;
      s5_r.q_y         <= '0;
      s5_r.side.status <= s4_status_r;
      s5_r.side.neg_x  <= s4_neg_x_r;
      s5_r.side.neg_y  <= s4_neg_y_r;
      s5_r.side.ovf_x  <= (num_x_c >= lim_c);
      s5_r.side.ovf_y  <= (num_y_c >= lim_c);
      s5_r.side.px     <= {s4_col_r, {spc_pkg::OUT_FRAC{1'b0}}};
      s5_r.side.py     <= {s4_row_r, {spc_pkg::OUT_FRAC{1'b0}}};
    end
  end

  assign up_ready = rdy[0];
  assign dn_valid = v_r[4];
  assign dn_data  = s5_r;

endmodule
`default_nettype wire

FILE: hw/rtl/spc_cell.sv
`default_nettype none
module spc_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              up_valid,
  output logic              up_ready,
  input  spc_pkg::spc_div_t up_data,
  output logic              dn_valid,
  input  logic              dn_ready,
  output spc_pkg::spc_div_t dn_data
);

  logic              v_r;
  spc_pkg::spc_div_t d_r;
  spc_pkg::spc_div_t d_nxt;
  logic              ge_x, ge_y;

  // One restoring step for both coordinates against the shared divisor.
  always_comb begin
    ge_x  = up_data.rem_x >= up_data.dvs;
    ge_y  = up_data.rem_y >= up_data.dvs;
    d_nxt = up_data;
    d_nxt.rem_x = ge_x ? up_data.rem_x - up_data.dvs : up_data.rem_x;
    d_nxt.rem_y = ge_y ? up_data.rem_y - up_data.dvs : up_data.rem_y;
    d_nxt.q_x   = {up_data.q_x[spc_pkg::QUO_W-2:0], ge_x};
    d_nxt.q_y   = {up_data.q_y[spc_pkg::QUO_W-2:0], ge_y};
    d_nxt.dvs   = {1'b0, up_data.dvs[spc_pkg::REM_W-1:1]};
  end

  assign up_ready = !v_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      d_r <= d_nxt;
    end
  end

  assign dn_valid = v_r;
  assign dn_data  = d_r;

endmodule
`default_nettype wire

FILE: hw/rtl/subpixel_peak_centroid_3x3.sv
`default_nettype none
// Subpixel peak refinement by 3x3 centroid. Each input word carries the nine
// signed Q1.14 scores around an integer correlation peak and the peak column and
// row; the result word gives the score-weighted centroid in unsigned Q12.8,
// rounded to nearest (ties away from zero) and clamped to 0 .. 2^20-1. A peak on
// the border of the match space (set by space_width and space_height, each
// clamped to 4096) returns status 1 with the integer peak shifted into Q12.8; a
// zero score sum returns status 2 with the same integer peak. One word is taken
// every clock cycle while the output is not stalled; a result word passes through
// 26 register stages: five set-up stages (partial sums, full sum, coordinate
// multiply, magnitude, divider set-up), a chain of 20 divider cells producing
// one quotient bit each for both coordinates, and the output register. The
// configuration port is always ready; write it only while no word is in flight.
`include "subpixel_peak_centroid_3x3_assert.svh"
module subpixel_peak_centroid_3x3 (
  input  logic       clk,
  input  logic       rst_n,
  spc_in_if.sink     in_chan,
  spc_out_if.source  out_chan,
  spc_cfg_if.sink    cfg_chan
);

  logic [spc_pkg::DIM_W-1:0]    space_width_r;
  logic [spc_pkg::DIM_W-1:0]    space_height_r;
  spc_pkg::spc_dims_t           dims;
  spc_pkg::spc_in_t             in_word;

  // Link 0 is the set-up pipeline output; link k+1 is cell k's output.
  logic                         link_v   [spc_pkg::N_CELLS+1];
  logic                         link_rdy [spc_pkg::N_CELLS+1];
  spc_pkg::spc_div_t            link_d   [spc_pkg::N_CELLS+1];

  logic                         out_valid_r;
  logic [spc_pkg::OUT_W-1:0]    out_x_r, out_x_nxt;
  logic [spc_pkg::OUT_W-1:0]    out_y_r, out_y_nxt;
  logic [spc_pkg::STATUS_W-1:0] out_status_r;
  logic                         out_take;
  spc_pkg::spc_div_t            last;

  // Configuration registers: write on every valid word, ignore unknown indexes.
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      space_width_r  <= spc_pkg::DIM_RESET;
      space_height_r <= spc_pkg::DIM_RESET;
    end else if (cfg_chan.valid) begin
      case (cfg_chan.index)
        spc_pkg::CFG_SPACE_WIDTH:  space_width_r  <= cfg_chan.data;
        spc_pkg::CFG_SPACE_HEIGHT: space_height_r <= cfg_chan.data;
        default: ;
      endcase
    end
  end

  assign dims.width  = space_width_r;
  assign dims.height = space_height_r;

  always_comb begin
    in_word.score_up_left    = in_chan.score_up_left;
    in_word.score_up         = in_chan.score_up;
    in_word.score_up_right   = in_chan.score_up_right;
    in_word.score_left       = in_chan.score_left;
    in_word.score_center     = in_chan.score_center;
    in_word.score_right      = in_chan.score_right;
    in_word.score_down_left  = in_chan.score_down_left;
    in_word.score_down       = in_chan.score_down;
    in_word.score_down_right = in_chan.score_down_right;
    in_word.peak_col         = in_chan.peak_col;
    in_word.peak_row         = in_chan.peak_row;
  end

  // Sums, multiply and divider set-up.
  spc_prep u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .dims     (dims),
    .up_valid (in_chan.valid),
    .up_ready (in_chan.ready),
    .up_data  (in_word),
    .dn_valid (link_v[0]),
    .dn_ready (link_rdy[0]),
    .dn_data  (link_d[0])
  );

  // Divider chain: each cell settles one quotient bit, most significant first.
  for (genvar k = 0; k < spc_pkg::N_CELLS; k++) begin : g_cell
    spc_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (link_v[k]),
      .up_ready (link_rdy[k]),
      .up_data  (link_d[k]),
      .dn_valid (link_v[k+1]),
      .dn_ready (link_rdy[k+1]),
      .dn_data  (link_d[k+1])
    );
  end

  // Output register: take a word when empty or when the sink drains it.
  assign out_take = !out_valid_r || out_chan.ready;
  assign link_rdy[spc_pkg::N_CELLS] = out_take;
  assign last = link_d[spc_pkg::N_CELLS];

  // Select integer peak on border or zero sum, clamp negative to 0 and overflow
  // to full scale, else take the quotient.
  always_comb begin
    if (last.side.status != spc_pkg::ST_OK) begin
      out_x_nxt = last.side.px;
      out_y_nxt = last.side.py;
    end else begin
      out_x_nxt = last.side.neg_x ? '0 : (last.side.ovf_x ? spc_pkg::OUT_MAX : last.q_x);
      out_y_nxt = last.side.neg_y ? '0 : (last.side.ovf_y ? spc_pkg::OUT_MAX : last.q_y);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_take) begin
      out_valid_r <= link_v[spc_pkg::N_CELLS];
    end
  end

  always_ff @(posedge clk) begin
    if (out_take && link_v[spc_pkg::N_CELLS]) begin
      out_x_r      <= out_x_nxt;
      out_y_r      <= out_y_nxt;
      out_status_r <= last.side.status;
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.refined_x = out_x_r;
  assign out_chan.refined_y = out_y_r;
  assign out_chan.status    = out_status_r;

  // Input may stall only when every stage is full and the output is blocked.
  `SPC_ASSERT_IMP(a_stall_only_when_full, !in_chan.ready, out_valid_r && !out_chan.ready, "input stalled with room in pipeline")
  // Border and zero-sum results carry the integer peak, so no fraction bits.
  `SPC_ASSERT_IMP(a_int_peak_frac, out_valid_r && (out_status_r != spc_pkg::ST_OK), (out_x_r[spc_pkg::OUT_FRAC-1:0] == '0) && (out_y_r[spc_pkg::OUT_FRAC-1:0] == '0), "fallback result has fraction bits")
  // A finished word at the end of the chain holds until the output register takes it.
  `SPC_ASSERT_NXT(a_chain_end_hold, link_v[spc_pkg::N_CELLS] && !link_rdy[spc_pkg::N_CELLS], link_v[spc_pkg::N_CELLS], "divider chain dropped a word")

endmodule
`default_nettype wire
